// ===== rtl/cdak_pkg.sv =====
// Shared constants, types and helpers for the colour-distance alpha key.
// Used by the top level, the root pipeline and the port checker.
package cdak_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;

    // Squared channel difference, sum of three of them, and the scaled limit.
    localparam int SQ_W   = 2 * CHANNEL_BITS;
    localparam int DIST_W = SQ_W + 2;
    localparam int LIM_W  = 2 * CHANNEL_BITS + DIST_W;

    localparam int S_TDATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((4 * CHANNEL_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FG_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FG_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BG_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BG_BLUE  = 3'd5;

    localparam logic [CHANNEL_BITS-1:0] FG_RESET = CHANNEL_BITS'(255);
    localparam logic [CHANNEL_BITS-1:0] BG_RESET = '0;

    // One word in flight through the square-root stages.
    typedef struct packed {
        logic [3*CHANNEL_BITS-1:0] rgb;
        logic [CHANNEL_BITS-1:0]   alpha;
        logic [LIM_W-1:0]          sq_acc;
        logic [LIM_W-1:0]          lin_acc;
        logic [DIST_W-1:0]         dmax;
        logic [LIM_W-1:0]          lim;
    } root_t;

    function automatic logic [CHANNEL_BITS-1:0] absdiff(
        input logic [CHANNEL_BITS-1:0] a,
        input logic [CHANNEL_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/cdak_root.sv =====
// Bit-per-stage square-root comparison pipeline for the alpha key.
// Depends on cdak_pkg for widths and the root_t word type.
module cdak_root (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cdak_pkg::root_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output cdak_pkg::root_t out_item
);

    localparam int NST = cdak_pkg::CHANNEL_BITS;
    localparam int LW  = cdak_pkg::LIM_W;

    logic            v_reg  [NST];
    cdak_pkg::root_t st_reg [NST];
    logic            pv     [NST];
    cdak_pkg::root_t pi     [NST];
    logic [NST:0]    rdy;

    assign rdy[NST]  = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_item  = st_reg[NST-1];

    for (genvar i = 0; i < NST; i++) begin : g_stage
        localparam int B = NST - 1 - i;
        logic            en;
        logic [LW-1:0]   cand;
        logic            take;
        cdak_pkg::root_t st_next;

        if (i == 0) begin : g_first
            assign pv[i] = in_valid;
            assign pi[i] = in_item;
        end else begin : g_rest
            assign pv[i] = v_reg[i-1];
            assign pi[i] = st_reg[i-1];
        end

        assign en     = !v_reg[i] || rdy[i+1];
        assign rdy[i] = en;

        // (a + 2^B)^2 * dmax built from the running a^2*dmax and a*dmax.
        always_comb begin
            cand = pi[i].sq_acc + (pi[i].lin_acc << (B + 1))
                 + (LW'(pi[i].dmax) << (2 * B));
            take = (cand <= pi[i].lim);
            st_next = pi[i];
            if (take) begin
                st_next.alpha[B] = 1'b1;
                st_next.sq_acc   = cand;
                st_next.lin_acc  = pi[i].lin_acc + (LW'(pi[i].dmax) << B);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= pv[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i] <= st_next;
            end
        end
    end

endmodule

// ===== rtl/color_distance_alpha_key.sv =====
// Top level of the colour-distance alpha key: configuration registers,
// difference, square, sum and limit stages, then the cdak_root pipeline.
// Depends on cdak_pkg and cdak_root.
//
// Usage: pixels enter on the s_ stream, one word per pixel carrying red,
// green and blue. Each word leaves on the m_ stream with the same three
// channels and an alpha equal to the colour distance from the background,
// scaled so that the foreground colour gives full opacity and saturated
// at the channel maximum.
// There are four front stages and one stage per alpha bit. One word is
// accepted per cycle while the receiver takes words (m_tready high).
// Every stage holds a valid bit and only stalls when it is full and the
// stage after it cannot take its word, so a stalled receiver fills the
// empty stages first and s_tready falls only when the pipeline is full.
// The user must write colours through the cfg_ port only while the stream is
// idle; the block does not enforce this. Reset (aresetn low, synchronous)
// empties the pipeline and sets the foreground to white, background to black.
module color_distance_alpha_key (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pix_red, pix_green, pix_blue, zero padding
    input  logic [cdak_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_red, out_green, out_blue, alpha, zero padding
    output logic [cdak_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [cdak_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cdak_pkg::CHANNEL_BITS-1:0]   cfg_data
);

    localparam int CB = cdak_pkg::CHANNEL_BITS;
    localparam int SW = cdak_pkg::SQ_W;
    localparam int DW = cdak_pkg::DIST_W;
    localparam int LW = cdak_pkg::LIM_W;

    logic [CB-1:0] fg_reg [3];
    logic [CB-1:0] bg_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                fg_reg[k] <= cdak_pkg::FG_RESET;
                bg_reg[k] <= cdak_pkg::BG_RESET;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cdak_pkg::REG_FG_RED:   fg_reg[0] <= cfg_data;
                cdak_pkg::REG_FG_GREEN: fg_reg[1] <= cfg_data;
                cdak_pkg::REG_FG_BLUE:  fg_reg[2] <= cfg_data;
                cdak_pkg::REG_BG_RED:   bg_reg[0] <= cfg_data;
                cdak_pkg::REG_BG_GREEN: bg_reg[1] <= cfg_data;
                cdak_pkg::REG_BG_BLUE:  bg_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 en1, en2, en3, en4;
    logic                 root_ready;
    logic [3*CB-1:0]      rgb1_reg, rgb2_reg, rgb3_reg;
    logic [CB-1:0]        dp1_reg [3];
    logic [CB-1:0]        df1_reg [3];
    logic [SW-1:0]        sp2_reg [3];
    logic [SW-1:0]        sf2_reg [3];
    logic [DW-1:0]        dpix3_reg, dmax3_reg;
    logic [DW-1:0]        dmax_sum;
    logic [LW-1:0]        dpix_ext;
    cdak_pkg::root_t      r4_reg, r4_next;
    logic                 root_out_valid;
    cdak_pkg::root_t      root_out;

    assign en4      = !v4_reg || root_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    assign dmax_sum = DW'(sf2_reg[0]) + DW'(sf2_reg[1]) + DW'(sf2_reg[2]);
    assign dpix_ext = LW'(dpix3_reg);

    // The limit is (2^CB - 1)^2 * dpix, formed with shifts and adds.
    always_comb begin
        r4_next         = '0;
        r4_next.rgb     = rgb3_reg;
        r4_next.dmax    = dmax3_reg;
        r4_next.lim     = (dpix_ext << (2 * CB)) - (dpix_ext << (CB + 1)) + dpix_ext;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            rgb1_reg <= s_tdata[3*CB-1:0];
            for (int k = 0; k < 3; k++) begin
                dp1_reg[k] <= cdak_pkg::absdiff(s_tdata[k*CB +: CB], bg_reg[k]);
                df1_reg[k] <= cdak_pkg::absdiff(fg_reg[k], bg_reg[k]);
            end
        end
        if (en2) begin
            rgb2_reg <= rgb1_reg;
            for (int k = 0; k < 3; k++) begin
                sp2_reg[k] <= SW'(dp1_reg[k]) * SW'(dp1_reg[k]);
                sf2_reg[k] <= SW'(df1_reg[k]) * SW'(df1_reg[k]);
            end
        end
        if (en3) begin
            rgb3_reg  <= rgb2_reg;
            dpix3_reg <= DW'(sp2_reg[0]) + DW'(sp2_reg[1]) + DW'(sp2_reg[2]);
            dmax3_reg <= (dmax_sum == '0) ? DW'(1) : dmax_sum;
        end
        if (en4) begin
            r4_reg <= r4_next;
        end
    end

    cdak_root u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v4_reg),
        .in_ready  (root_ready),
        .in_item   (r4_reg),
        .out_valid (root_out_valid),
        .out_ready (m_tready),
        .out_item  (root_out)
    );

    assign m_tvalid = root_out_valid;
    assign m_tdata  = cdak_pkg::M_TDATA_W'({root_out.alpha, root_out.rgb});

endmodule

// ===== rtl/cdak_checker.sv =====
// Port-level checks for the colour-distance alpha key, bound to the top level.
// Depends on cdak_pkg for the stream width.
module cdak_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cdak_pkg::M_TDATA_W-1:0] m_tdata
);

    // A word on offer is held until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped or changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // With the output stage free to move, the input is never held off.
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready || !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage can move");

    // The input is held off only when a word waits at the output, so s_tready
    // cannot be low with no output.
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with nothing at the output");

endmodule

bind color_distance_alpha_key cdak_checker u_cdak_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the colour-distance alpha key.
// It streams pixels under several colour settings and idling patterns and checks each output
// word against an integer model of the alpha. Depends on cdak_pkg and color_distance_alpha_key.
module tb;

    typedef logic [cdak_pkg::CHANNEL_BITS-1:0] chan_t;
    typedef longint unsigned wide_t;

    typedef struct packed {
        chan_t alpha;
        chan_t blue;
        chan_t green;
        chan_t red;
    } keyed_pixel_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam logic [cdak_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [cdak_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam wide_t FULL = (wide_t'(1) << cdak_pkg::CHANNEL_BITS) - 1;
    localparam int LATENCY = 4 + cdak_pkg::CHANNEL_BITS;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BLOCKS = 8;
    localparam int BLOCK_PIXELS = 100;

    class alpha_predictor;
        chan_t fg[3];
        chan_t bg[3];
        keyed_pixel_t awaited[$];
        int mismatches;

        function new();
            foreach (fg[i]) begin
                fg[i] = cdak_pkg::FG_RESET;
                bg[i] = cdak_pkg::BG_RESET;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [cdak_pkg::CFG_IDX_W-1:0] idx, chan_t val);
            case (idx)
                cdak_pkg::REG_FG_RED:   fg[0] = val;
                cdak_pkg::REG_FG_GREEN: fg[1] = val;
                cdak_pkg::REG_FG_BLUE:  fg[2] = val;
                cdak_pkg::REG_BG_RED:   bg[0] = val;
                cdak_pkg::REG_BG_GREEN: bg[1] = val;
                cdak_pkg::REG_BG_BLUE:  bg[2] = val;
                default: ;
            endcase
        endfunction

        function wide_t sq_gap(chan_t a, chan_t b);
            wide_t d;
            d = (a >= b) ? wide_t'(a - b) : wide_t'(b - a);
            return d * d;
        endfunction

        // Largest alpha whose square, scaled by the key distance, stays within the pixel's.
        function chan_t opacity(wide_t pix_sq, wide_t key_sq);
            wide_t lo, hi, mid, bound, key;
            lo = 0;
            hi = FULL;
            key = (key_sq == 0) ? 1 : key_sq;
            bound = FULL * FULL * pix_sq;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (mid * mid * key <= bound) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            return chan_t'(lo);
        endfunction

        function void note_pixel(logic [cdak_pkg::S_TDATA_W-1:0] word);
            keyed_pixel_t px;
            wide_t pix_sq, key_sq;
            px.red   = word[cdak_pkg::CHANNEL_BITS-1:0];
            px.green = word[2*cdak_pkg::CHANNEL_BITS-1:cdak_pkg::CHANNEL_BITS];
            px.blue  = word[3*cdak_pkg::CHANNEL_BITS-1:2*cdak_pkg::CHANNEL_BITS];
            pix_sq = sq_gap(px.red, bg[0]) + sq_gap(px.green, bg[1]) + sq_gap(px.blue, bg[2]);
            key_sq = sq_gap(fg[0], bg[0]) + sq_gap(fg[1], bg[1]) + sq_gap(fg[2], bg[2]);
            px.alpha = opacity(pix_sq, key_sq);
            awaited = {awaited, px};
        endfunction

        function void compare(string field, chan_t want, chan_t seen);
            if (want !== seen) begin
                $error("%s: expected %0d, got %0d", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_word(logic [cdak_pkg::M_TDATA_W-1:0] word);
            keyed_pixel_t want, seen;
            seen = keyed_pixel_t'(word[4*cdak_pkg::CHANNEL_BITS-1:0]);
            if (awaited.size() == 0) begin
                $error("unexpected word %h with no pixel outstanding", word);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare("out_red", want.red, seen.red);
            compare("out_green", want.green, seen.green);
            compare("out_blue", want.blue, seen.blue);
            compare("alpha", want.alpha, seen.alpha);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [cdak_pkg::S_TDATA_W-1:0]     s_tdata = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [cdak_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                               cfg_wr_en = 1'b0;
    logic [cdak_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    chan_t                              cfg_data = '0;

    alpha_predictor keyer;
    bit sender_idles = 1'b0;
    bit receiver_stalls = 1'b0;
    int idle_pct = 79;
    int quiet_cycles = 0;

    color_distance_alpha_key uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= receiver_stalls ? (int'($urandom_range(99)) >= idle_pct) : 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                keyer.note_pixel(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                keyer.check_word(m_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("color_distance_alpha_key regression: fail");
            $finish;
        end
    end

    task automatic set_idling(idle_mode_t mode);
        sender_idles = (mode == IDLE_SENDER) || (mode == IDLE_BOTH);
        receiver_stalls = (mode == IDLE_RECEIVER) || (mode == IDLE_BOTH);
        idle_pct = (mode == IDLE_BOTH) ? 19 : 79;
    endtask

    task automatic send_pixel(chan_t r, chan_t g, chan_t b);
        while (sender_idles && int'($urandom_range(99)) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= cdak_pkg::S_TDATA_W'({b, g, r});
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (keyer.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Leaves the write enable high so that back-to-back writes need no second assignment.
    task automatic write_reg(logic [cdak_pkg::CFG_IDX_W-1:0] idx, chan_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        keyer.write_reg(idx, val);
    endtask

    task automatic set_colours(chan_t fg_r, chan_t fg_g, chan_t fg_b,
                               chan_t bg_r, chan_t bg_g, chan_t bg_b);
        drain();
        write_reg(cdak_pkg::REG_FG_RED, fg_r);
        write_reg(cdak_pkg::REG_FG_GREEN, fg_g);
        write_reg(cdak_pkg::REG_FG_BLUE, fg_b);
        write_reg(cdak_pkg::REG_BG_RED, bg_r);
        write_reg(cdak_pkg::REG_BG_GREEN, bg_g);
        write_reg(cdak_pkg::REG_BG_BLUE, bg_b);
        if ($urandom_range(2) == 0) begin
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, chan_t'($urandom));
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic chan_t nudge(chan_t c);
        int v;
        v = int'(c) + int'($urandom_range(16)) - 8;
        if (v < 0) begin
            v = 0;
        end else if (v > int'(FULL)) begin
            v = int'(FULL);
        end
        return chan_t'(v);
    endfunction

    function automatic chan_t pick_end();
        return $urandom_range(1) ? chan_t'(FULL) : chan_t'(0);
    endfunction

    task automatic random_colours();
        chan_t f[3];
        chan_t k[3];
        int scheme;
        scheme = $urandom_range(9);
        for (int i = 0; i < 3; i++) begin
            k[i] = (scheme >= 5 && scheme <= 6) ? pick_end() : chan_t'($urandom);
            case (scheme)
                5, 6: f[i] = pick_end();
                7, 8: f[i] = nudge(k[i]);
                9: f[i] = k[i];
                default: f[i] = chan_t'($urandom);
            endcase
        end
        set_colours(f[0], f[1], f[2], k[0], k[1], k[2]);
    endtask

    task automatic send_random_pixel();
        chan_t ch[3];
        int mode;
        mode = $urandom_range(3);
        for (int i = 0; i < 3; i++) begin
            case (mode)
                1: ch[i] = nudge(keyer.bg[i]);
                2: ch[i] = nudge(keyer.fg[i]);
                3: ch[i] = pick_end();
                default: ch[i] = chan_t'($urandom);
            endcase
        end
        send_pixel(ch[0], ch[1], ch[2]);
    endtask

    initial begin
        keyer = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // White on black straight after reset.
        set_idling(IDLE_NONE);
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        send_pixel(128, 128, 128);
        send_pixel(1, 0, 0);
        send_pixel(254, 255, 255);

        // Pixels at the foreground, at the background and beyond the foreground.
        set_colours(200, 100, 50, 20, 40, 60);
        send_pixel(200, 100, 50);
        send_pixel(20, 40, 60);
        send_pixel(255, 255, 255);
        send_pixel(0, 0, 0);

        // Foreground equal to background: any other pixel saturates.
        set_colours(77, 77, 77, 77, 77, 77);
        send_pixel(77, 77, 77);
        send_pixel(78, 77, 77);
        send_pixel(0, 0, 0);

        // Writes to unused indexes must leave the colours alone.
        set_colours(0, 0, 0, 255, 255, 255);
        @(posedge aclk);
        write_reg(REG_SPARE_LO, 8'h5a);
        write_reg(REG_SPARE_HI, 8'ha5);
        cfg_wr_en <= 1'b0;
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(255, 0, 255);

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            random_colours();
            set_idling(idle_mode_t'(blk % 4));
            for (int n = 0; n < BLOCK_PIXELS; n++) begin
                send_random_pixel();
            end
        end

        drain();
        repeat (2 * LATENCY) @(posedge aclk);
        if (keyer.mismatches == 0 && keyer.pending() == 0) begin
            $display("color_distance_alpha_key regression: pass");
        end else begin
            $display("color_distance_alpha_key regression: fail");
        end
        $finish;
    end
endmodule
